@@ hw/rtl/lfr_pkg.sv @@
`timescale 1ns / 1ps
// lfr_pkg: shared widths, request codes, register indexes and result word type
// for the length-prefixed frame receiver. No dependencies.

package lfr_pkg;

   // field widths fixed by the interface
   localparam int BYTE_W = 8;
   localparam int IDX_W  = 7;
   localparam int LEN_W  = 8;
   localparam int IDLE_W = 16;
   localparam int CSR_W  = 16;

   // default frame buffer depth
   localparam int MAX_LEN_DEFAULT = 128;

   // register reset values, the idle limit used when zero is written, and idle count saturation
   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'h00;
   localparam logic [IDLE_W-1:0] IDLE_LIMIT_RESET = 16'd8;
   localparam logic [IDLE_W-1:0] IDLE_LIMIT_ZERO  = 16'd8;
   localparam logic [IDLE_W-1:0] IDLE_SAT         = 16'hFFFF;

   // result queue depth
   localparam int QDEPTH = 3;

   // request codes
   typedef enum logic [1:0] {
      REQ_BYTE = 2'd0,
      REQ_IDLE = 2'd1,
      REQ_READ = 2'd2
   } req_kind_type;

   // register indexes
   typedef enum logic {
      CSR_START_BYTE = 1'b0,
      CSR_IDLE_LIMIT = 1'b1
   } csr_index_type;

   // one result word
   typedef struct packed {
      logic              frame_done;
      logic [LEN_W-1:0]  frame_length;
      logic              overflow_abort;
      logic              timeout_abort;
      logic              in_frame;
      logic [BYTE_W-1:0] read_data;
   } result_type;

endpackage

@@ hw/rtl/length_prefixed_frame_receiver.sv @@
`timescale 1ns / 1ps
// length_prefixed_frame_receiver: top level of the frame receiver.
// Depends on lfr_pkg and lfr_ram.
//
// Usage
// - req channel (valid/ready): one word per request. req_type selects a
//   received byte (req_rx_byte), an idle tick, or a read of the last
//   completed frame at req_read_index.
// - rsp channel (valid/ready): exactly one result word per request, in order.
//   It carries frame done, overflow and timeout flags, the length of the last
//   completed frame, the collecting state after the request, and read data.
// - csr port: start byte (index 0) and idle limit (index 1), written while
//   csr_we is high; write only while the block is idle.
// Each request passes the buffer stage register (frame buffer read), then the
// result queue write, before rsp_valid rises.
// Throughput: one request per cycle while the result queue has room; the
// frame buffer has separate write and read ports and each request uses at
// most one of them.
// Reset clears the collecting state, counters, last length and registers;
// the frame buffer is not cleared and needs no sweep. When rsp_ready is low
// the three-entry result queue fills and req_ready drops; no word is lost.

module length_prefixed_frame_receiver
   import lfr_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_type,
   input  logic [BYTE_W-1:0] req_rx_byte,
   input  logic [IDX_W-1:0]  req_read_index,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_frame_done,
   output logic [LEN_W-1:0]  rsp_frame_length,
   output logic              rsp_overflow_abort,
   output logic              rsp_timeout_abort,
   output logic              rsp_in_frame,
   output logic [BYTE_W-1:0] rsp_read_data,
   // register write port
   input  logic              csr_we,
   input  logic              csr_addr,
   input  logic [CSR_W-1:0]  csr_wdata
);

   localparam int AW    = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int CMP_W = (CNT_W > BYTE_W) ? CNT_W : BYTE_W;
   localparam int QPW   = $clog2(QDEPTH);
   localparam int QCW   = $clog2(QDEPTH + 1);

   // registers
   logic [BYTE_W-1:0] start_byte_ff;
   logic [IDLE_W-1:0] idle_limit_ff;

   // collection state
   logic              collecting_ff, collecting_in;
   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0] len_byte_ff, len_byte_in;
   logic [LEN_W-1:0]  last_length_ff, last_length_in;
   logic [IDLE_W-1:0] idle_count_ff, idle_count_in;

   // buffer access stage
   logic              s1_valid_ff;
   result_type        s1_res_ff, s1_res_in;
   logic              s1_rd_ok_ff, s1_rd_ok_in;

   // result queue
   result_type        q_mem_ff [QDEPTH];
   logic [QPW-1:0]    q_wr_ptr_ff, q_rd_ptr_ff;
   logic [QCW-1:0]    q_count_ff;

   // buffer port
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [BYTE_W-1:0] ram_rd_data;

   logic              accept;
   logic              push;
   logic              pop;
   logic [CNT_W-1:0]  count_inc;
   logic [BYTE_W-1:0] len_sel;
   logic [IDLE_W-1:0] idle_inc;
   logic [IDLE_W-1:0] limit_eff;
   logic              idx_ok;
   result_type        s1_full;

   assign accept = req_valid && req_ready;
   assign push   = s1_valid_ff;
   assign pop    = rsp_valid && rsp_ready;

   // room for the word in the buffer stage plus the new one
   assign req_ready = ({1'b0, q_count_ff} + (QCW+1)'(s1_valid_ff)) < (QCW+1)'(QDEPTH);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         idle_limit_ff <= IDLE_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_START_BYTE: start_byte_ff <= csr_wdata[BYTE_W-1:0];
            CSR_IDLE_LIMIT: idle_limit_ff <= csr_wdata[IDLE_W-1:0];
            default: ;
         endcase
      end
   end

   // helper values for the request decode
   assign count_inc = byte_count_ff + CNT_W'(1);
   assign len_sel   = (byte_count_ff == CNT_W'(1)) ? req_rx_byte : len_byte_ff;
   assign idle_inc  = (idle_count_ff == IDLE_SAT) ? idle_count_ff : idle_count_ff + 16'd1;
   assign limit_eff = (idle_limit_ff == '0) ? IDLE_LIMIT_ZERO : idle_limit_ff;
   assign idx_ok    = (LEN_W'(req_read_index) < last_length_ff) &&
                      (32'(req_read_index) < MAX_LEN);

   // request decode: next state, buffer access and result word
   always_comb begin
      collecting_in  = collecting_ff;
      byte_count_in  = byte_count_ff;
      len_byte_in    = len_byte_ff;
      last_length_in = last_length_ff;
      idle_count_in  = idle_count_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = AW'(byte_count_ff);
      ram_wr_data    = req_rx_byte;
      ram_rd_en      = 1'b0;
      s1_rd_ok_in    = 1'b0;
      s1_res_in      = '0;

      if (accept) begin
         unique case (req_kind_type'(req_type))
            REQ_BYTE: begin
               idle_count_in = '0;
               if (!collecting_ff) begin
                  if (req_rx_byte == start_byte_ff) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_addr   = '0;
                     byte_count_in = CNT_W'(1);
                     collecting_in = 1'b1;
                  end
               end else if (byte_count_ff < CNT_W'(MAX_LEN)) begin
                  ram_wr_en     = 1'b1;
                  byte_count_in = count_inc;
                  if (byte_count_ff == CNT_W'(1)) begin
                     len_byte_in = req_rx_byte;
                  end
                  // the length byte gives the total frame size
                  if (CMP_W'(count_inc) == CMP_W'(len_sel)) begin
                     last_length_in       = LEN_W'(count_inc);
                     s1_res_in.frame_done = 1'b1;
                     collecting_in        = 1'b0;
                     byte_count_in        = '0;
                  end
               end else begin
                  s1_res_in.overflow_abort = 1'b1;
                  collecting_in            = 1'b0;
                  byte_count_in            = '0;
               end
            end
            REQ_IDLE: begin
               idle_count_in = idle_inc;
               if (idle_inc >= limit_eff) begin
                  idle_count_in           = '0;
                  s1_res_in.timeout_abort = collecting_ff;
                  collecting_in           = 1'b0;
                  byte_count_in           = '0;
               end
            end
            REQ_READ: begin
               ram_rd_en   = idx_ok;
               s1_rd_ok_in = idx_ok;
            end
            default: ;
         endcase
         s1_res_in.frame_length = last_length_in;
         s1_res_in.in_frame     = collecting_in;
      end
   end

   // state and buffer stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         collecting_ff  <= 1'b0;
         byte_count_ff  <= '0;
         last_length_ff <= '0;
         idle_count_ff  <= '0;
         s1_valid_ff    <= 1'b0;
      end else begin
         collecting_ff  <= collecting_in;
         byte_count_ff  <= byte_count_in;
         last_length_ff <= last_length_in;
         idle_count_ff  <= idle_count_in;
         s1_valid_ff    <= accept;
      end
   end

   always_ff @(posedge clock) begin
      len_byte_ff <= len_byte_in;
      if (accept) begin
         s1_res_ff   <= s1_res_in;
         s1_rd_ok_ff <= s1_rd_ok_in;
      end
   end

   // frame buffer
   lfr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (AW'(req_read_index)),
      .rd_data (ram_rd_data)
   );

   // merge read data into the result word
   always_comb begin
      s1_full           = s1_res_ff;
      s1_full.read_data = s1_rd_ok_ff ? ram_rd_data : '0;
   end

   // result queue
   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ptr_ff <= '0;
         q_rd_ptr_ff <= '0;
         q_count_ff  <= '0;
      end else begin
         if (push) begin
            q_wr_ptr_ff <= (q_wr_ptr_ff == QPW'(QDEPTH - 1)) ? '0 : q_wr_ptr_ff + QPW'(1);
         end
         if (pop) begin
            q_rd_ptr_ff <= (q_rd_ptr_ff == QPW'(QDEPTH - 1)) ? '0 : q_rd_ptr_ff + QPW'(1);
         end
         q_count_ff <= q_count_ff + QCW'(push) - QCW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[q_wr_ptr_ff] <= s1_full;
      end
   end

   // result outputs
   assign rsp_valid          = (q_count_ff != '0);
   assign rsp_frame_done     = q_mem_ff[q_rd_ptr_ff].frame_done;
   assign rsp_frame_length   = q_mem_ff[q_rd_ptr_ff].frame_length;
   assign rsp_overflow_abort = q_mem_ff[q_rd_ptr_ff].overflow_abort;
   assign rsp_timeout_abort  = q_mem_ff[q_rd_ptr_ff].timeout_abort;
   assign rsp_in_frame       = q_mem_ff[q_rd_ptr_ff].in_frame;
   assign rsp_read_data      = q_mem_ff[q_rd_ptr_ff].read_data;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CNT_W'(MAX_LEN))
      else $error("byte count past buffer depth");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      !collecting_ff |-> (byte_count_ff == '0))
      else $error("byte count nonzero outside a frame");

   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, q_count_ff} + (QCW+1)'(s1_valid_ff)) <= (QCW+1)'(QDEPTH))
      else $error("result queue overrun");

   a_overflow: assert property (@(posedge clock) disable iff (reset)
      (accept && req_type == REQ_BYTE && collecting_ff &&
       byte_count_ff == CNT_W'(MAX_LEN))
      |=> (s1_valid_ff && s1_res_ff.overflow_abort && !collecting_ff))
      else $error("full frame not aborted");

endmodule

@@ hw/rtl/lfr_ram.sv @@
`timescale 1ns / 1ps
// lfr_ram: generic single-write, single-read synchronous RAM with registered
// read data. No dependencies.

module lfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
